// ===== hw/rtl/lznt_pkg.sv =====
// Package for the LZNT1 chunk decompressor.
// Holds field widths, command and status codes, and the walk phase type.
// No dependencies.
package lznt_pkg;

    localparam int CHUNK_BYTES_DEF = 4096;
    localparam int BUDGET_W        = 25;
    localparam int CNT_W           = 13;

    localparam logic [BUDGET_W-1:0] BUDGET_RST = BUDGET_W'(4096);

    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADREF   = 3'd2;
    localparam logic [2:0] ST_TOOLARGE = 3'd3;
    localparam logic [2:0] ST_BADRAW   = 3'd4;
    localparam logic [2:0] ST_BUDGET   = 3'd5;
    localparam logic [2:0] ST_BUSY     = 3'd6;

    typedef enum logic [2:0] {
        PH_HDR_LO,
        PH_HDR_HI,
        PH_TAG,
        PH_TOKEN,
        PH_REF_HI,
        PH_COPY,
        PH_RAW,
        PH_ERROR
    } phase_t;

endpackage

// ===== hw/rtl/lznt_hist.sv =====
// History window memory: one write port, one registered read port.
// A read of the entry written in the same cycle returns the new byte.
// Depends on lznt_pkg.
module lznt_hist import lznt_pkg::*; #(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
    parameter int AW          = $clog2(CHUNK_BYTES)
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [CHUNK_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first on an address collision
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/lznt1_chunk_decompressor_top.sv =====
// LZNT1 chunk decompressor, top level.
// Walk control, one pipeline stage after the history read, output register.
// Depends on lznt_pkg and lznt_hist.
//
//  channel | direction | ports                                          | transfer when
//  --------+-----------+------------------------------------------------+----------------------
//  input   | in        | s_command, s_data_byte                         | s_valid & s_ready
//  result  | out       | m_out_byte, m_byte_valid, m_last_of_chunk,     | m_valid & m_ready
//          |           | m_status                                       |
//  config  | in        | cfg_wdata (output budget)                      | cfg_we
//
// One item per clock while no result is held. An accepted item updates the walk
// state in its cycle and, for a copy tick, issues the history read; it then
// enters the stage after the read, which writes the byte back into the window
// and passes the result to the output register. A stalled result holds the
// stage behind it; input is taken again as soon as that stage can move.
// aresetn is synchronous. The window is not cleared; reads only reach bytes
// written earlier in the same chunk.
module lznt1_chunk_decompressor_top import lznt_pkg::*; #(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [BUDGET_W-1:0] cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [7:0]          s_data_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_byte_valid,
    output logic                m_last_of_chunk,
    output logic [2:0]          m_status
);

    localparam int AW    = $clog2(CHUNK_BYTES);
    localparam int POS_W = AW + 1;
    localparam logic [POS_W-1:0] CHUNK_POS = POS_W'(CHUNK_BYTES);

    // walk state
    phase_t              phase_reg, phase_next;
    logic [2:0]          err_reg, err_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    cleft_reg, cleft_next;
    logic [7:0]          hdr_lo_reg, hdr_lo_next;
    logic [7:0]          tag_reg, tag_next;
    logic [3:0]          tok_reg, tok_next;
    logic [7:0]          ref_lo_reg, ref_lo_next;
    logic [CNT_W-1:0]    copy_left_reg, copy_left_next;
    logic [AW-1:0]       copy_dist_reg, copy_dist_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [BUDGET_W-1:0] cfg_budget_reg;

    // stage after the history read
    logic          p1_valid_reg, p1_has_reg, p1_mem_reg, p1_wr_reg;
    logic [AW-1:0] p1_waddr_reg;
    logic [7:0]    p1_byte_reg;
    logic          p1_bv_reg, p1_last_reg;
    logic [2:0]    p1_status_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bv_reg, out_last_reg;
    logic [2:0] out_status_reg;

    logic       acc, p1_adv;
    logic [7:0] hist_rdata, p1_byte;

    // decode of the accepted item
    logic          res_has, res_bv, res_last, res_mem, res_wr, res_fail, rd_en;
    logic [7:0]    res_byte;
    logic [2:0]    res_status;
    logic [AW-1:0] res_waddr, rd_addr;

    logic [CNT_W-1:0] cl_dec;
    logic [3:0]       tok_dec;
    logic [7:0]       tag_shr;
    logic [15:0]      hdr_word, ref_word, ref_dist;
    logic [CNT_W-1:0] hdr_len, ref_len;
    logic [POS_W-1:0] idx;
    logic [4:0]       idx_bits;
    logic [3:0]       shrink, dshift;
    logic [11:0]      lmask;
    logic             tick_bad, ref_bad;

    assign p1_adv  = !p1_valid_reg || !p1_has_reg || !out_valid_reg || m_ready;
    assign s_ready = p1_adv;
    assign acc     = s_valid && s_ready;

    // shared arithmetic
    always_comb begin
        cl_dec   = cleft_reg - CNT_W'(1);
        tok_dec  = (tok_reg == 4'd0) ? 4'd0 : tok_reg - 4'd1;
        tag_shr  = {1'b0, tag_reg[7:1]};
        hdr_word = {s_data_byte, hdr_lo_reg};
        hdr_len  = CNT_W'(hdr_word[11:0]) + CNT_W'(1);
        ref_word = {s_data_byte, ref_lo_reg};
        idx      = pos_reg - POS_W'(1);
        idx_bits = '0;
        for (int i = 0; i < POS_W; i++) begin
            if (idx[i]) idx_bits = 5'(i + 1);
        end
        // length field shrinks one bit per doubling past 16, down to none
        if (idx_bits <= 5'd4)       shrink = 4'd0;
        else if (idx_bits >= 5'd16) shrink = 4'd12;
        else                        shrink = 4'(idx_bits - 5'd4);
        dshift   = 4'd12 - shrink;
        lmask    = 12'hFFF >> shrink;
        ref_dist = ref_word >> dshift;
        ref_len  = CNT_W'(ref_word[11:0] & lmask) + CNT_W'(3);
        ref_bad  = (32'(ref_dist) > 32'(idx)) ||
                   (32'(ref_len) > 32'(CHUNK_BYTES) - 32'(pos_reg));
        tick_bad = (pos_reg >= CHUNK_POS) || (32'(copy_dist_reg) + 32'd1 > 32'(pos_reg));
        rd_addr  = pos_reg[AW-1:0] - copy_dist_reg - AW'(1);
    end

    // result of the accepted item
    always_comb begin
        res_has    = 1'b0;
        res_bv     = 1'b0;
        res_last   = 1'b0;
        res_mem    = 1'b0;
        res_wr     = 1'b0;
        res_fail   = 1'b0;
        res_byte   = 8'd0;
        res_status = ST_OK;
        res_waddr  = pos_reg[AW-1:0];
        rd_en      = 1'b0;
        if (s_command == CMD_RESTART || s_command == CMD_SPARE) begin
            res_has = 1'b0;
        end else if (phase_reg == PH_ERROR) begin
            res_has    = 1'b1;
            res_status = err_reg;
        end else if (s_command == CMD_TICK) begin
            if (phase_reg == PH_COPY) begin
                if (tick_bad) begin
                    res_fail   = 1'b1;
                    res_status = ST_BADREF;
                end else begin
                    res_has  = 1'b1;
                    res_bv   = 1'b1;
                    res_mem  = 1'b1;
                    res_wr   = 1'b1;
                    rd_en    = acc;
                    res_last = (copy_left_reg <= CNT_W'(1)) && (cleft_reg == '0);
                end
            end
        end else begin
            case (phase_reg)
                PH_HDR_HI: begin
                    if (!hdr_word[15] && (32'(hdr_len) != 32'(CHUNK_BYTES))) begin
                        res_fail   = 1'b1;
                        res_status = ST_BADRAW;
                    end
                end
                PH_TAG: begin
                    if (cl_dec == '0) begin
                        res_has  = 1'b1;
                        res_last = 1'b1;
                    end
                end
                PH_TOKEN: begin
                    if (tag_reg[0]) begin
                        if (cl_dec == '0) begin
                            res_fail   = 1'b1;
                            res_status = ST_BADREF;
                        end
                    end else if (pos_reg >= CHUNK_POS) begin
                        res_fail   = 1'b1;
                        res_status = ST_TOOLARGE;
                    end else if (budget_reg == '0) begin
                        res_fail   = 1'b1;
                        res_status = ST_BUDGET;
                    end else begin
                        res_has  = 1'b1;
                        res_bv   = 1'b1;
                        res_wr   = 1'b1;
                        res_byte = s_data_byte;
                        res_last = (cl_dec == '0);
                    end
                end
                PH_REF_HI: begin
                    if (pos_reg >= CHUNK_POS) begin
                        res_fail   = 1'b1;
                        res_status = ST_TOOLARGE;
                    end else if (pos_reg == '0) begin
                        res_fail   = 1'b1;
                        res_status = ST_EMPTY;
                    end else if (ref_bad) begin
                        res_fail   = 1'b1;
                        res_status = ST_BADREF;
                    end else if (budget_reg < BUDGET_W'(ref_len)) begin
                        res_fail   = 1'b1;
                        res_status = ST_BUDGET;
                    end
                end
                PH_COPY: begin
                    res_has    = 1'b1;
                    res_status = ST_BUSY;
                end
                PH_RAW: begin
                    if (budget_reg == '0) begin
                        res_fail   = 1'b1;
                        res_status = ST_BUDGET;
                    end else begin
                        res_has  = 1'b1;
                        res_bv   = 1'b1;
                        res_byte = s_data_byte;
                        res_last = (cl_dec == '0);
                    end
                end
                default: begin
                    res_has = 1'b0;
                end
            endcase
        end
        if (res_fail) begin
            res_has = 1'b1;
        end
    end

    // walk next state
    always_comb begin
        phase_next     = phase_reg;
        err_next       = err_reg;
        pos_next       = pos_reg;
        cleft_next     = cleft_reg;
        hdr_lo_next    = hdr_lo_reg;
        tag_next       = tag_reg;
        tok_next       = tok_reg;
        ref_lo_next    = ref_lo_reg;
        copy_left_next = copy_left_reg;
        copy_dist_next = copy_dist_reg;
        budget_next    = budget_reg;
        if (acc) begin
            if (s_command == CMD_RESTART) begin
                phase_next     = PH_HDR_LO;
                err_next       = ST_OK;
                pos_next       = '0;
                cleft_next     = '0;
                hdr_lo_next    = '0;
                tag_next       = '0;
                tok_next       = '0;
                ref_lo_next    = '0;
                copy_left_next = '0;
                copy_dist_next = '0;
                budget_next    = cfg_budget_reg;
            end else if (res_fail) begin
                phase_next = PH_ERROR;
                err_next   = res_status;
            end else if (s_command == CMD_TICK) begin
                if (phase_reg == PH_COPY) begin
                    pos_next = pos_reg + POS_W'(1);
                    if (copy_left_reg != '0) copy_left_next = copy_left_reg - CNT_W'(1);
                    if (copy_left_reg <= CNT_W'(1)) begin
                        if (cleft_reg == '0)     phase_next = PH_HDR_LO;
                        else if (tok_reg == '0)  phase_next = PH_TAG;
                        else                     phase_next = PH_TOKEN;
                    end
                end
            end else if (s_command == CMD_BYTE) begin
                case (phase_reg)
                    PH_HDR_LO: begin
                        hdr_lo_next = s_data_byte;
                        phase_next  = PH_HDR_HI;
                    end
                    PH_HDR_HI: begin
                        pos_next   = '0;
                        tok_next   = '0;
                        tag_next   = '0;
                        cleft_next = hdr_len;
                        phase_next = hdr_word[15] ? PH_TAG : PH_RAW;
                    end
                    PH_TAG: begin
                        cleft_next = cl_dec;
                        tag_next   = s_data_byte;
                        tok_next   = 4'd8;
                        phase_next = (cl_dec == '0) ? PH_HDR_LO : PH_TOKEN;
                    end
                    PH_TOKEN: begin
                        cleft_next = cl_dec;
                        if (tag_reg[0]) begin
                            ref_lo_next = s_data_byte;
                            phase_next  = PH_REF_HI;
                        end else begin
                            pos_next    = pos_reg + POS_W'(1);
                            budget_next = budget_reg - BUDGET_W'(1);
                            tag_next    = tag_shr;
                            tok_next    = tok_dec;
                            if (cl_dec == '0)       phase_next = PH_HDR_LO;
                            else if (tok_dec == '0) phase_next = PH_TAG;
                            else                    phase_next = PH_TOKEN;
                        end
                    end
                    PH_REF_HI: begin
                        cleft_next     = cl_dec;
                        budget_next    = budget_reg - BUDGET_W'(ref_len);
                        copy_dist_next = ref_dist[AW-1:0];
                        copy_left_next = ref_len;
                        tag_next       = tag_shr;
                        tok_next       = tok_dec;
                        phase_next     = PH_COPY;
                    end
                    PH_RAW: begin
                        budget_next = budget_reg - BUDGET_W'(1);
                        cleft_next  = cl_dec;
                        if (pos_reg < CHUNK_POS) pos_next = pos_reg + POS_W'(1);
                        if (cl_dec == '0) phase_next = PH_HDR_LO;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HDR_LO;
            err_reg        <= ST_OK;
            pos_reg        <= '0;
            cleft_reg      <= '0;
            hdr_lo_reg     <= '0;
            tag_reg        <= '0;
            tok_reg        <= '0;
            ref_lo_reg     <= '0;
            copy_left_reg  <= '0;
            copy_dist_reg  <= '0;
            budget_reg     <= BUDGET_RST;
            cfg_budget_reg <= BUDGET_RST;
        end else begin
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            pos_reg       <= pos_next;
            cleft_reg     <= cleft_next;
            hdr_lo_reg    <= hdr_lo_next;
            tag_reg       <= tag_next;
            tok_reg       <= tok_next;
            ref_lo_reg    <= ref_lo_next;
            copy_left_reg <= copy_left_next;
            copy_dist_reg <= copy_dist_next;
            budget_reg    <= budget_next;
            if (cfg_we) cfg_budget_reg <= cfg_wdata;
        end
    end

    // stage after the read: copy bytes come from the window
    assign p1_byte = p1_mem_reg ? hist_rdata : p1_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p1_wr_reg    <= 1'b0;
        end else if (p1_adv) begin
            p1_valid_reg <= acc;
            p1_wr_reg    <= acc && res_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            p1_has_reg    <= res_has;
            p1_mem_reg    <= res_mem;
            p1_waddr_reg  <= res_waddr;
            p1_byte_reg   <= res_byte;
            p1_bv_reg     <= res_bv;
            p1_last_reg   <= res_last;
            p1_status_reg <= res_status;
        end
    end

    lznt_hist #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .AW          (AW)
    ) u_hist (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (p1_valid_reg && p1_wr_reg),
        .wr_addr (p1_waddr_reg),
        .wr_data (p1_byte),
        .rd_data (hist_rdata)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_valid_reg && p1_has_reg && p1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg && p1_has_reg && p1_adv) begin
            out_byte_reg   <= p1_byte;
            out_bv_reg     <= p1_bv_reg;
            out_last_reg   <= p1_last_reg;
            out_status_reg <= p1_status_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_byte_valid    = out_bv_reg;
    assign m_last_of_chunk = out_last_reg;
    assign m_status        = out_status_reg;

    // a data byte never carries an error code
    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_status == ST_OK)
        else $error("byte result with nonzero status");

    // a pending copy always has bytes left
    a_copy_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_COPY |-> copy_left_reg != '0)
        else $error("copy phase with empty count");

    // input stalls only behind a held result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> p1_valid_reg && p1_has_reg && out_valid_reg && !m_ready)
        else $error("input stalled without cause");

    // sticky error carries its code
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ERROR |-> err_reg != ST_OK)
        else $error("error phase without code");

endmodule
